// ===== sv/slns_pkg.sv =====
`timescale 1ns / 1ps

package slns_pkg;

   // Field widths of the request, the response and the registers
   localparam int unsigned BAT_W   = 7;
   localparam int unsigned TICK_W  = 16;
   localparam int unsigned LEVEL_W = 8;
   localparam int unsigned PHASE_W = 4;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 16;
   localparam int unsigned REQ_DATA_W = 16;
   localparam int unsigned RSP_DATA_W = 32;

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_NOTIFY_ENABLE     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GPS_ENABLED       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BATTERY_THRESHOLD = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FLASH_TICKS       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PAUSE_TICKS       = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LOOP_TICKS        = 3'd5;

   // Register values after reset
   localparam logic [BAT_W-1:0]  RST_BATTERY_THRESHOLD = 7'd20;
   localparam logic [TICK_W-1:0] RST_FLASH_TICKS       = 16'd24;
   localparam logic [TICK_W-1:0] RST_PAUSE_TICKS       = 16'd244;
   localparam logic [TICK_W-1:0] RST_LOOP_TICKS        = 16'd976;

   // Phase codes; odd codes and codes above idle are pause phases, which switch the drive off when their wait runs out
   localparam logic [PHASE_W-1:0] PH_BAT  = 4'd0;
   localparam logic [PHASE_W-1:0] PH_GPS  = 4'd2;
   localparam logic [PHASE_W-1:0] PH_LNC  = 4'd4;
   localparam logic [PHASE_W-1:0] PH_LOK  = 4'd6;
   localparam logic [PHASE_W-1:0] PH_IDLE = 4'd8;

   // Drive levels
   localparam logic [LEVEL_W-1:0] LEVEL_OFF  = 8'h00;
   localparam logic [LEVEL_W-1:0] LEVEL_FULL = 8'hFF;
   localparam logic [LEVEL_W-1:0] LEVEL_HALF = 8'h7F;

   typedef struct packed {
      logic              notify_enable;
      logic              gps_enabled;
      logic [BAT_W-1:0]  battery_threshold;
      logic [TICK_W-1:0] flash_ticks;
      logic [TICK_W-1:0] pause_ticks;
      logic [TICK_W-1:0] loop_ticks;
   } cfg_type;

   typedef struct packed {
      logic              link_connected;
      logic              link_ready;
      logic              gps_fix_valid;
      logic [BAT_W-1:0]  battery_percent;
   } tick_type;

   typedef struct packed {
      logic [TICK_W-1:0]  wait_count;
      logic [PHASE_W-1:0] phase;
      logic [LEVEL_W-1:0] red_drive;
      logic [LEVEL_W-1:0] green_drive;
      logic [LEVEL_W-1:0] blue_drive;
   } seq_state_type;

   typedef struct packed {
      logic               led_power;
      logic [LEVEL_W-1:0] blue_level;
      logic [LEVEL_W-1:0] green_level;
      logic [LEVEL_W-1:0] red_level;
   } result_type;

endpackage

// ===== sv/status_led_notify_sequencer.sv =====
`timescale 1ns / 1ps

// Status LED notification sequencer. Each request is one timer tick carrying the battery
// charge and the GPS and Bluetooth status; each tick gives exactly one response with the
// RGB drive levels and the LED power enable as they stand after that tick. A request is held
// in an input register and the phase logic runs in one pass into the response register; one
// request is taken in every cycle while the response side keeps up. The sequencer state
// advances only when a response is produced. Registers must be written through the csr port
// only while no tick is in flight, which the block does not enforce; with notify_enable
// cleared the ticks report the drive without changing it.
module status_led_notify_sequencer
   import slns_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // Request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // Fields from bit 0: battery_percent[6:0], gps_fix_valid, link_ready, link_connected
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // Response channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // Fields from bit 0: red_level[7:0], green_level[7:0], blue_level[7:0], led_power
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // Configuration write port
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int unsigned TICK_BITS = $bits(tick_type);
   localparam int unsigned RES_BITS  = $bits(result_type);

   cfg_type       cfg;
   logic          in_valid_ff;
   tick_type      in_tick_ff;
   logic          out_valid_ff;
   result_type    out_res_ff;
   seq_state_type state_ff;
   seq_state_type state_in;
   result_type    res_in;
   logic          fire;

   slns_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   slns_step u_step (
      .cfg  (cfg),
      .tick (in_tick_ff),
      .cur  (state_ff),
      .nxt  (state_in),
      .res  (res_in)
   );

   // A held tick is processed when the response register is free or being emptied.
   assign fire       = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || fire;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_tick_ff <= tick_type'(req_tdata[TICK_BITS-1:0]);
      end
   end

   // Sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.wait_count  <= '0;
         state_ff.phase       <= PH_IDLE;
         state_ff.red_drive   <= LEVEL_OFF;
         state_ff.green_drive <= LEVEL_OFF;
         state_ff.blue_drive  <= LEVEL_OFF;
      end else if (fire) begin
         state_ff <= state_in;
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (fire) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_res_ff <= res_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-RES_BITS){1'b0}}, out_res_ff};

   // The state moves only when a tick is turned into a response.
   assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(state_ff))
      else $error("sequencer state changed without a processed tick");

   // A response held back by the consumer is not overwritten.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !fire)
      else $error("response register overwritten while stalled");

   // The power enable follows the levels it reports.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (out_res_ff.led_power ==
         ((out_res_ff.red_level | out_res_ff.green_level | out_res_ff.blue_level) != '0)))
      else $error("led_power does not match the reported levels");

   // A new response appears only after a processed tick.
   assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(fire))
      else $error("response valid without a processed tick");

endmodule

// ===== sv/slns_csr.sv =====
`timescale 1ns / 1ps

module slns_csr
   import slns_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode a write into the addressed register; unknown indexes are ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_NOTIFY_ENABLE:     cfg_in.notify_enable     = csr_wdata[0];
            CSR_GPS_ENABLED:       cfg_in.gps_enabled       = csr_wdata[0];
            CSR_BATTERY_THRESHOLD: cfg_in.battery_threshold = csr_wdata[BAT_W-1:0];
            CSR_FLASH_TICKS:       cfg_in.flash_ticks       = csr_wdata[TICK_W-1:0];
            CSR_PAUSE_TICKS:       cfg_in.pause_ticks       = csr_wdata[TICK_W-1:0];
            CSR_LOOP_TICKS:        cfg_in.loop_ticks        = csr_wdata[TICK_W-1:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.notify_enable     <= 1'b0;
         cfg_ff.gps_enabled       <= 1'b1;
         cfg_ff.battery_threshold <= RST_BATTERY_THRESHOLD;
         cfg_ff.flash_ticks       <= RST_FLASH_TICKS;
         cfg_ff.pause_ticks       <= RST_PAUSE_TICKS;
         cfg_ff.loop_ticks        <= RST_LOOP_TICKS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== sv/slns_step.sv =====
`timescale 1ns / 1ps

module slns_step
   import slns_pkg::*;
(
   input  cfg_type       cfg,
   input  tick_type      tick,
   input  seq_state_type cur,
   output seq_state_type nxt,
   output result_type    res
);

   logic bat_alarm;
   logic gps_alarm;
   logic lnc_alarm;
   logic lok_alarm;
   logic pause_phase;

   // Alarms that apply from the current phase onwards
   assign bat_alarm = (cur.phase == PH_BAT) && (tick.battery_percent < cfg.battery_threshold);
   assign gps_alarm = (cur.phase <= PH_GPS) && cfg.gps_enabled && !tick.gps_fix_valid;
   assign lnc_alarm = (cur.phase <= PH_LNC) && tick.link_ready && !tick.link_connected;
   assign lok_alarm = (cur.phase <= PH_LOK) && tick.link_ready && tick.link_connected;
   assign pause_phase = cur.phase[0] || (cur.phase > PH_IDLE);

   // Enabled tick: count down, run a pause, light the first alarm due, or loop.
   always_comb begin
      nxt = cur;
      if (cfg.notify_enable) begin
         if (cur.wait_count != '0) begin
            nxt.wait_count = cur.wait_count - 1'b1;
         end else if (pause_phase) begin
            nxt.wait_count  = cfg.pause_ticks;
            nxt.phase       = cur.phase + 1'b1;
            nxt.red_drive   = LEVEL_OFF;
            nxt.green_drive = LEVEL_OFF;
            nxt.blue_drive  = LEVEL_OFF;
         end else if (bat_alarm) begin
            nxt.wait_count  = cfg.flash_ticks;
            nxt.phase       = PH_BAT + 1'b1;
            nxt.red_drive   = LEVEL_FULL;
            nxt.green_drive = LEVEL_OFF;
            nxt.blue_drive  = LEVEL_OFF;
         end else if (gps_alarm) begin
            nxt.wait_count  = cfg.flash_ticks;
            nxt.phase       = PH_GPS + 1'b1;
            nxt.red_drive   = LEVEL_FULL;
            nxt.green_drive = LEVEL_FULL;
            nxt.blue_drive  = LEVEL_OFF;
         end else if (lnc_alarm) begin
            nxt.wait_count  = cfg.flash_ticks;
            nxt.phase       = PH_LNC + 1'b1;
            nxt.red_drive   = LEVEL_OFF;
            nxt.green_drive = LEVEL_FULL;
            nxt.blue_drive  = LEVEL_HALF;
         end else if (lok_alarm) begin
            nxt.wait_count  = cfg.flash_ticks;
            nxt.phase       = PH_LOK + 1'b1;
            nxt.red_drive   = LEVEL_OFF;
            nxt.green_drive = LEVEL_OFF;
            nxt.blue_drive  = LEVEL_FULL;
         end else begin
            // Nothing to show: wait the loop time, then start again.
            nxt.wait_count = cfg.loop_ticks;
            nxt.phase      = PH_BAT;
         end
      end
   end

   // The response reports the drive as it stands after this tick.
   assign res.red_level   = nxt.red_drive;
   assign res.green_level = nxt.green_drive;
   assign res.blue_level  = nxt.blue_drive;
   assign res.led_power   = (nxt.red_drive | nxt.green_drive | nxt.blue_drive) != '0;

endmodule
